// File: sv/assert_macros.svh
// Assertion helpers used by the allocator RTL.
// They are compiled away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property checked on every rising clock edge outside of reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be true outside of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_PROP(label, clk, rst_n, !(cond), msg)

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// File: sv/sfid_pkg.sv
package sfid_pkg;

	// Field widths of the stream payloads.
	localparam int VALUE_W = 11;
	localparam int TDATA_W = 16;

	// The bitmap is stored as words of this many bits.
	localparam int WORD_W   = 64;
	localparam int BIT_W    = 6;

	// Operation codes carried in tuser of the input stream.
	localparam logic OP_TAKE = 1'b0;
	localparam logic OP_GIVE = 1'b1;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [BIT_W-1:0]  bit_idx_t;

	typedef enum logic {
		ST_IDLE,
		ST_MODIFY
	} state_t;

	// Index of the lowest set bit of a bitmap word; zero for an empty word.
	function automatic bit_idx_t lowest_bit(input word_t w);
		bit_idx_t idx;
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

// File: sv/smallest_free_id_allocator.sv
// Lowest free id allocator.
// Input stream (s_*): s_tuser is the operation (0 = take, 1 = give back),
// s_tdata carries the number given back, which a take ignores.
// Output stream (m_*): one transaction per take, none per give-back.
// m_tdata carries the number handed out, m_tuser flags exhaustion (data 0).
// Numbers run from 1 to VALUE_MAX. Give-backs of 0, of numbers at or above
// the frontier and of numbers already returned are dropped.
// Every transaction is accepted in the idle state, where its bitmap word is
// read from the RAM, and then passes through the modify state, which writes
// the word back. The block takes no new transaction until the last one has
// left the modify state; this is set by the single RAM read-modify-write.
// A take result reaches m_* through the modify state and the output register.
// A result waiting on m_* does not block the input: a new transaction is
// still accepted, and only a take that finds the output register full
// waits in its modify cycle until the receiver takes the pending result.
// Reset sets the frontier to 1 and clears the per-word occupancy flags in
// one step; the RAM needs no clearing pass, a word whose flag is clear
// reads as empty.
`include "assert_macros.svh"

module smallest_free_id_allocator import sfid_pkg::*; #(
	parameter int VALUE_MAX = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // [10:0] value, [15:11] zero
	input  logic               s_tuser,   // [0] operation
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [10:0] taken_value, [15:11] zero
	output logic               m_tuser    // [0] exhausted
);

	localparam int NWORDS  = (VALUE_MAX + WORD_W) / WORD_W;
	localparam int WIDX_W  = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int FRESH_W = $clog2(VALUE_MAX + 2);

	// Control state.
	state_t             state_q, state_d;
	logic [FRESH_W-1:0] fresh_q;
	logic [NWORDS-1:0]  summary_q;

	// Item held through the modify cycle.
	logic               op_s1;
	logic               hit_s1;
	logic               give_ok_s1;
	logic [WIDX_W-1:0]  widx_s1;
	bit_idx_t           bit_s1;

	// Output register.
	logic               m_tvalid_q;
	logic [VALUE_W-1:0] m_value_q;
	logic               m_exh_q;

	logic               accept;
	logic               sum_any;
	logic [WIDX_W-1:0]  sum_idx;
	logic [31:0]        value_ext;
	logic [WIDX_W-1:0]  give_widx;
	logic               give_ok;
	logic               rd_en;
	logic [WIDX_W-1:0]  rd_addr;
	word_t              rd_data;
	word_t              base_word;
	bit_idx_t           take_bit;
	word_t              new_word;
	logic               wr_en;
	logic               out_free;
	logic               load_out;
	logic [VALUE_W-1:0] out_value;
	logic               out_exh;
	logic               fresh_inc;
	logic               sum_wr;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Lowest word of the bitmap that holds a returned number.
	always_comb begin
		sum_idx = '0;
		for (int i = NWORDS - 1; i >= 0; i--) begin
			if (summary_q[i]) begin
				sum_idx = WIDX_W'(i);
			end
		end
	end
	assign sum_any = |summary_q;

	// Give-back address and range check against the frontier.
	assign value_ext = 32'(s_tdata[VALUE_W-1:0]);
	assign give_widx = WIDX_W'(value_ext >> BIT_W);
	assign give_ok   = (value_ext != 32'd0) && (value_ext < 32'(fresh_q));

	// The word is read in the accept cycle.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = sum_idx;
		if (accept) begin
			if (s_tuser == OP_GIVE) begin
				rd_en   = give_ok;
				rd_addr = give_widx;
			end else begin
				rd_en   = sum_any;
				rd_addr = sum_idx;
			end
		end
	end

	sfid_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NWORDS)
	) u_map_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (widx_s1),
		.wr_data (new_word),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// A word whose occupancy flag is clear counts as empty.
	assign base_word = summary_q[widx_s1] ? rd_data : '0;
	assign take_bit  = lowest_bit(base_word);
	assign out_free  = !m_tvalid_q || m_tready;

	// Modify cycle: update the word, the frontier and the result.
	always_comb begin
		state_d   = state_q;
		wr_en     = 1'b0;
		new_word  = base_word;
		load_out  = 1'b0;
		out_value = '0;
		out_exh   = 1'b0;
		fresh_inc = 1'b0;
		sum_wr    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_MODIFY;
				end
			end
			ST_MODIFY: begin
				if (op_s1 == OP_GIVE) begin
					state_d  = ST_IDLE;
					new_word = base_word | (word_t'(1) << bit_s1);
					wr_en    = give_ok_s1;
					sum_wr   = give_ok_s1;
				end else if (out_free) begin
					state_d  = ST_IDLE;
					load_out = 1'b1;
					if (hit_s1) begin
						new_word  = base_word & ~(word_t'(1) << take_bit);
						wr_en     = 1'b1;
						sum_wr    = 1'b1;
						out_value = VALUE_W'((32'(widx_s1) << BIT_W) | 32'(take_bit));
					end else if (fresh_q <= FRESH_W'(VALUE_MAX)) begin
						fresh_inc = 1'b1;
						out_value = VALUE_W'(32'(fresh_q));
					end else begin
						out_exh = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Frontier counter and per-word occupancy flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q   <= FRESH_W'(1);
			summary_q <= '0;
		end else begin
			if (fresh_inc) begin
				fresh_q <= fresh_q + FRESH_W'(1);
			end
			if (sum_wr) begin
				summary_q[widx_s1] <= |new_word;
			end
		end
	end

	// Item details kept for the modify cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= s_tuser;
			hit_s1     <= sum_any;
			give_ok_s1 <= give_ok;
			widx_s1    <= (s_tuser == OP_GIVE) ? give_widx : sum_idx;
			bit_s1     <= s_tdata[BIT_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_value_q <= out_value;
			m_exh_q   <= out_exh;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = TDATA_W'(m_value_q);
	assign m_tuser  = m_exh_q;

	// The frontier never runs past one beyond the top number.
	`ASSERT_NEVER(a_fresh_range, clk, arst_n, 32'(fresh_q) > 32'(VALUE_MAX + 1),
		"frontier beyond range")
	// A word flagged as occupied really holds a returned number.
	`ASSERT_PROP(a_hit_nonempty, clk, arst_n,
		(state_q == ST_MODIFY && op_s1 == OP_TAKE && hit_s1) |-> (rd_data != '0),
		"occupied word read back empty")
	// A result is loaded only into a free output register.
	`ASSERT_PROP(a_no_overwrite, clk, arst_n, load_out |-> (!m_tvalid_q || m_tready),
		"result overwrote a pending transaction")
	// Exhaustion is reported only with no returned number and a spent frontier.
	`ASSERT_PROP(a_exh_cause, clk, arst_n,
		(load_out && out_exh) |-> (!hit_s1 && 32'(fresh_q) == 32'(VALUE_MAX + 1)),
		"exhaustion reported while numbers remain")

endmodule

// File: sv/sfid_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module sfid_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 17,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: dv/sfid_checker.sv
`timescale 1ns / 100ps

// Watches both streams of the allocator, predicts every grant and compares.
module sfid_checker import sfid_pkg::*; #(
	parameter int VALUE_MAX = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // [10:0] value, [15:11] zero
	input  logic               s_tuser,   // [0] operation
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [TDATA_W-1:0] m_tdata,   // [10:0] taken_value, [15:11] zero
	input  logic               m_tuser,   // [0] exhausted
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic [VALUE_W-1:0] taken_value;
		logic               exhausted;
	} grant_t;

	// Grants predicted but not yet seen on the output stream, oldest first.
	grant_t grants_due[$];

	// Predictor state: lowest never-issued number and the given-back numbers.
	int unsigned frontier;
	bit          given_back [1:VALUE_MAX];

	// Smallest given-back number first, then the frontier, else exhaustion.
	function automatic grant_t next_grant();
		grant_t g;
		g = '0;
		for (int n = 1; n <= VALUE_MAX; n++) begin
			if (given_back[n]) begin
				given_back[n] = 1'b0;
				g.taken_value = VALUE_W'(n);
				return g;
			end
		end
		if (frontier <= VALUE_MAX) begin
			g.taken_value = VALUE_W'(frontier);
			frontier++;
		end else begin
			g.exhausted = 1'b1;
		end
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		grant_t got;
		logic [VALUE_W-1:0] val;
		if (!arst_n) begin
			frontier = 1;
			foreach (given_back[n]) begin
				given_back[n] = 1'b0;
			end
			grants_due.delete();
		end else begin
			// Compare an accepted grant with the oldest prediction.
			if (m_tvalid && m_tready) begin
				got.taken_value = m_tdata[VALUE_W-1:0];
				got.exhausted   = m_tuser;
				if (grants_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected grant: expected none, got value %0d exhausted %0b",
						$time, got.taken_value, got.exhausted);
				end else begin
					want = grants_due.pop_front();
					if (got.taken_value !== want.taken_value) begin
						errors++;
						$display("%0t: taken_value mismatch: expected %0d, got %0d",
							$time, want.taken_value, got.taken_value);
					end
					if (got.exhausted !== want.exhausted) begin
						errors++;
						$display("%0t: exhausted mismatch: expected %0b, got %0b",
							$time, want.exhausted, got.exhausted);
					end
				end
			end
			// Update the predictor with an accepted request.
			if (s_tvalid && s_tready) begin
				val = s_tdata[VALUE_W-1:0];
				if (s_tuser == OP_GIVE) begin
					if (val != 0 && val < frontier && val <= VALUE_MAX) begin
						given_back[val] = 1'b1;
					end
				end else begin
					grants_due.push_back(next_grant());
				end
			end
		end
		pending = grants_due.size();
	end

endmodule

// File: dv/smallest_free_id_allocator_tb.sv
`timescale 1ns / 100ps

module smallest_free_id_allocator_tb;
	import sfid_pkg::*;

	localparam int VALUE_MAX = 1024;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata;
	logic               s_tuser;
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tuser;

	int errors;
	int pending;

	// Traffic shaping, set per phase.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_left      = 0;

	// Stimulus bookkeeping.
	int                 takes_sent     = 0;
	int                 exhausted_seen = 0;
	logic [VALUE_W-1:0] last_give      = '0;

	smallest_free_id_allocator #(
		.VALUE_MAX(VALUE_MAX)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	sfid_checker #(
		.VALUE_MAX(VALUE_MAX)
	) checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
	end
	always #5 clk = ~clk;

	// Exhausted grants tell the stimulus when the number space has run dry.
	always @(posedge clk) begin
		if (m_tvalid && m_tready && m_tuser) begin
			exhausted_seen++;
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Run limit.
	initial begin
		#5_000_000;
		$display("smallest_free_id_allocator_tb failed");
		$finish;
	end

	// Offers one transaction after a random gap and returns at the falling
	// edge after it was accepted, with tvalid still high.
	task automatic send_item(input logic op, input logic [VALUE_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= TDATA_W'(val);
		do begin
			@(posedge clk);
		end while (!s_tready);
		if (op == OP_TAKE) begin
			takes_sent++;
		end else begin
			last_give = val;
		end
		@(negedge clk);
	endtask

	// Give-back values: mostly numbers already handed out, some repeats,
	// zeros and out-of-range noise.
	function automatic logic [VALUE_W-1:0] pick_give();
		int hi;
		int r;
		hi = (takes_sent < VALUE_MAX) ? takes_sent + 1 : VALUE_MAX;
		r  = $urandom_range(99);
		if (r < 5) begin
			return '0;
		end
		if (r < 12) begin
			return VALUE_W'($urandom_range(2047));
		end
		if (r < 20) begin
			return last_give;
		end
		return VALUE_W'($urandom_range(hi, 1));
	endfunction

	task automatic random_item(input int take_pct);
		if ($urandom_range(99) < take_pct) begin
			send_item(OP_TAKE, VALUE_W'($urandom_range(2047)));
		end else begin
			send_item(OP_GIVE, pick_give());
		end
	endtask

	// Drops tvalid and waits until every predicted grant has arrived.
	task automatic drain_grants();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = OP_TAKE;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Fresh numbers come from the frontier in order.
		send_item(OP_TAKE, '0);
		send_item(OP_TAKE, '0);
		send_item(OP_TAKE, '0);
		send_item(OP_TAKE, '0);
		// Zero, all ones, the frontier itself and the top value are dropped.
		send_item(OP_GIVE, '0);
		send_item(OP_GIVE, 11'd2047);
		send_item(OP_GIVE, 11'd5);
		send_item(OP_GIVE, 11'd1024);
		// A duplicate give-back changes nothing.
		send_item(OP_GIVE, 11'd3);
		send_item(OP_GIVE, 11'd3);
		send_item(OP_GIVE, 11'd1);
		send_item(OP_GIVE, 11'd4);
		// Given-back numbers come out smallest first, then the frontier resumes.
		send_item(OP_TAKE, 11'd2047);
		send_item(OP_TAKE, '0);
		send_item(OP_TAKE, '0);
		send_item(OP_TAKE, '0);
		send_item(OP_GIVE, 11'd2);
		send_item(OP_TAKE, '0);
		send_item(OP_TAKE, '0);
		// A value beyond the number space is dropped.
		send_item(OP_GIVE, 11'd1030);
		send_item(OP_TAKE, '0);

		// No idling on either side.
		repeat (250) random_item(70);

		// Sender mostly idle; then it pauses until the output is quiet.
		send_idle_pct = 67;
		repeat (250) random_item(70);
		drain_grants();

		// Receiver mostly stalling, opened by a long hold-off that backs up
		// the block while requests keep coming.
		send_idle_pct = 0;
		recv_stall_pct <= 67;
		hold_left <= 150;
		repeat (250) random_item(75);

		// Both sides idle at times; takes dominate until the space runs out.
		send_idle_pct = 26;
		recv_stall_pct <= 26;
		for (int guard = 0; guard < 2000 && exhausted_seen < 6; guard++) begin
			random_item(90);
		end

		// Churn on an exhausted allocator, starting with the top value.
		send_idle_pct = 0;
		recv_stall_pct <= 0;
		send_item(OP_GIVE, 11'd1024);
		send_item(OP_TAKE, '0);
		send_item(OP_TAKE, '0);
		repeat (250) random_item(50);

		// Let the last grants drain, then allow for any stray output.
		drain_grants();
		repeat (20) @(negedge clk);
		if (errors == 0) begin
			$display("smallest_free_id_allocator_tb passed");
		end else begin
			$display("smallest_free_id_allocator_tb failed");
		end
		$finish;
	end

endmodule
